@@ src/tenant_fair_share_tracker_macros.svh @@
// assertion macros used by the checker file
`ifndef TENANT_FAIR_SHARE_TRACKER_MACROS_SVH
`define TENANT_FAIR_SHARE_TRACKER_MACROS_SVH

// checked on every clock edge outside reset
`define TFST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define TFST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tfst_pkg.sv @@
`timescale 1ns / 1ps
package tfst_pkg;

	localparam int NUM_TENANTS = 4;
	localparam int TID_W       = 2;
	localparam int CNT_W       = 24;
	localparam int SHARE_W     = 17;
	localparam int ACT_W       = 3;
	localparam int PROD_W      = 40;
	localparam int SFALL_W     = 25;
	localparam int REG_IDX_W   = 3;

	localparam logic [SHARE_W-1:0] SHARE_WHOLE = 17'h10000;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_SCAN   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_UNKNOWN   = 2'd2,
		STS_SATURATED = 2'd3
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TOTAL  = 3'd0,
		REG_ACTIVE = 3'd1,
		REG_SHARE0 = 3'd2,
		REG_SHARE1 = 3'd3,
		REG_SHARE2 = 3'd4,
		REG_SHARE3 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic             load_in;
		logic             update;
		logic             mul;
		logic             cmp;
		logic             load_out;
		logic [TID_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
	} dp_stat_t;

endpackage

@@ src/tfst_ctrl.sv @@
`timescale 1ns / 1ps
module tfst_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tfst_pkg::kind_t                   in_kind,
	input  logic [tfst_pkg::TID_W-1:0]        in_tenant,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tfst_pkg::dp_cmd_t                 cmd,
	input  tfst_pkg::dp_stat_t                stat
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UPD  = 5'b00010,
		S_MUL  = 5'b00100,
		S_CMP  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                     state_q, state_d;
	logic [tfst_pkg::TID_W-1:0] idx_q, idx_d;
	logic                       out_valid_q;
	logic                       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		cmd          = '0;
		cmd.idx      = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (in_kind)
						tfst_pkg::KIND_ADD, tfst_pkg::KIND_REMOVE: begin
							state_d = S_UPD;
						end
						tfst_pkg::KIND_QUERY: begin
							idx_d   = in_tenant;
							state_d = S_MUL;
						end
						default: begin
							idx_d   = '0;
							state_d = S_MUL;
						end
					endcase
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_FIN;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				if (stat.kind == tfst_pkg::KIND_SCAN && idx_q != '1) begin
					idx_d   = idx_q + 1'b1;
					state_d = S_MUL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/tfst_dp.sv @@
`timescale 1ns / 1ps
module tfst_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [tfst_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [tfst_pkg::CNT_W-1:0]             cfg_data,
	input  tfst_pkg::kind_t                        in_kind,
	input  logic [tfst_pkg::TID_W-1:0]             in_tenant,
	input  logic [tfst_pkg::CNT_W-1:0]             in_count,
	input  tfst_pkg::dp_cmd_t                      cmd,
	output tfst_pkg::dp_stat_t                     stat,
	output logic [1:0]                             out_status,
	output logic signed [tfst_pkg::SFALL_W-1:0]    out_shortfall,
	output logic                                   out_found,
	output logic [tfst_pkg::TID_W-1:0]             out_best_tenant,
	output logic [tfst_pkg::CNT_W-1:0]             out_best_held,
	output logic [tfst_pkg::CNT_W-1:0]             out_best_excess
);

	localparam int NT = tfst_pkg::NUM_TENANTS;
	localparam int CW = tfst_pkg::CNT_W;

	logic [CW-1:0]                    total_q;
	logic [tfst_pkg::ACT_W-1:0]       active_q;
	logic [tfst_pkg::SHARE_W-1:0]     share_q [NT];
	logic [CW-1:0]                    held_q  [NT];

	tfst_pkg::kind_t                  kind_q;
	logic [tfst_pkg::TID_W-1:0]       tenant_q;
	logic [CW-1:0]                    count_q;
	logic [tfst_pkg::PROD_W-1:0]      prod_s1;

	logic [1:0]                       res_status_q;
	logic signed [tfst_pkg::SFALL_W-1:0] res_shortfall_q;
	logic                             res_found_q;
	logic [tfst_pkg::TID_W-1:0]       res_best_tenant_q;
	logic [CW-1:0]                    res_best_held_q;
	logic [CW-1:0]                    res_best_excess_q;

	logic [1:0]                       out_status_q;
	logic signed [tfst_pkg::SFALL_W-1:0] out_shortfall_q;
	logic                             out_found_q;
	logic [tfst_pkg::TID_W-1:0]       out_best_tenant_q;
	logic [CW-1:0]                    out_best_held_q;
	logic [CW-1:0]                    out_best_excess_q;

	logic [tfst_pkg::SHARE_W-1:0]     share_wr;
	logic [tfst_pkg::TID_W-1:0]       share_sel;
	logic                             share_we;
	logic [CW-1:0]                    held_cur;
	logic [CW:0]                      add_sum;
	logic                             rm_under;
	logic [CW-1:0]                    fair;
	logic [CW-1:0]                    fair_eff;
	logic [CW-1:0]                    held_i;
	logic                             idx_active;
	logic [CW-1:0]                    excess;

	// shares above one whole are stored as one whole
	assign share_wr  = (cfg_data[tfst_pkg::SHARE_W-1:0] > tfst_pkg::SHARE_WHOLE)
		? tfst_pkg::SHARE_WHOLE : cfg_data[tfst_pkg::SHARE_W-1:0];
	assign share_sel = tfst_pkg::TID_W'(cfg_index - tfst_pkg::REG_SHARE0);
	assign share_we  = cfg_valid && cfg_index >= tfst_pkg::REG_SHARE0
		&& cfg_index <= tfst_pkg::REG_SHARE3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			active_q <= tfst_pkg::ACT_W'(NT);
			for (int i = 0; i < NT; i++) begin
				share_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (tfst_pkg::reg_idx_t'(cfg_index))
					tfst_pkg::REG_TOTAL:  total_q  <= cfg_data;
					tfst_pkg::REG_ACTIVE: active_q <= cfg_data[tfst_pkg::ACT_W-1:0];
					default: ;
				endcase
			end
			if (share_we) begin
				share_q[share_sel] <= share_wr;
			end
		end
	end

	assign held_cur = held_q[tenant_q];
	assign add_sum  = {1'b0, held_cur} + {1'b0, count_q};
	assign rm_under = count_q > held_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				held_q[i] <= '0;
			end
		end else if (cmd.update) begin
			if (kind_q == tfst_pkg::KIND_ADD) begin
				held_q[tenant_q] <= add_sum[CW] ? tfst_pkg::CNT_MAX : add_sum[CW-1:0];
			end else if (!rm_under) begin
				held_q[tenant_q] <= held_cur - count_q;
			end
		end
	end

	// fair share never exceeds total_blocks, so its top bits are zero
	assign fair       = prod_s1[tfst_pkg::PROD_W-1:16];
	assign held_i     = held_q[cmd.idx];
	assign idx_active = {1'b0, cmd.idx} < active_q;
	assign fair_eff   = idx_active ? fair : '0;
	assign excess     = held_i - fair_eff;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q            <= in_kind;
			tenant_q          <= in_tenant;
			count_q           <= in_count;
			res_status_q      <= tfst_pkg::STS_OK;
			res_shortfall_q   <= '0;
			res_found_q       <= 1'b0;
			res_best_tenant_q <= '0;
			res_best_held_q   <= '0;
			res_best_excess_q <= '0;
		end
		if (cmd.update) begin
			if (kind_q == tfst_pkg::KIND_ADD) begin
				res_status_q <= add_sum[CW] ? tfst_pkg::STS_SATURATED : tfst_pkg::STS_OK;
			end else begin
				res_status_q <= rm_under ? tfst_pkg::STS_UNDERFLOW : tfst_pkg::STS_OK;
			end
		end
		if (cmd.mul) begin
			prod_s1 <= tfst_pkg::PROD_W'(total_q) * tfst_pkg::PROD_W'(share_q[cmd.idx]);
		end
		if (cmd.cmp) begin
			if (kind_q == tfst_pkg::KIND_QUERY) begin
				if (!idx_active) begin
					res_status_q <= tfst_pkg::STS_UNKNOWN;
				end else begin
					res_shortfall_q <= $signed({1'b0, fair} - {1'b0, held_i});
				end
			end else if (held_i > fair_eff && excess > res_best_excess_q) begin
				res_found_q       <= 1'b1;
				res_best_tenant_q <= cmd.idx;
				res_best_held_q   <= held_i;
				res_best_excess_q <= excess;
			end
		end
		if (cmd.load_out) begin
			out_status_q      <= res_status_q;
			out_shortfall_q   <= res_shortfall_q;
			out_found_q       <= res_found_q;
			out_best_tenant_q <= res_best_tenant_q;
			out_best_held_q   <= res_best_held_q;
			out_best_excess_q <= res_best_excess_q;
		end
	end

	assign stat.kind       = kind_q;
	assign out_status      = out_status_q;
	assign out_shortfall   = out_shortfall_q;
	assign out_found       = out_found_q;
	assign out_best_tenant = out_best_tenant_q;
	assign out_best_held   = out_best_held_q;
	assign out_best_excess = out_best_excess_q;

endmodule

@@ src/tenant_fair_share_tracker.sv @@
`timescale 1ns / 1ps
// an item is taken only in idle, so a new one waits until the last result is handed on;
// add and remove pass update then finish, a shortfall query one multiply/compare pair,
// the max-borrower scan one multiply/compare pair per tenant, four tenants, then finish;
// the single shared 24x17 multiplier has a registered product; finish waits on a stall
// reset: arst_n asynchronous active low; counts and shares clear, active_tenants is 4
module tenant_fair_share_tracker (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // tenant[1:0], count[25:2], zero pad[31:26]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // shortfall[24:0], found[25], best_tenant[27:26],
	                               // best_held[51:28], best_excess[75:52], zero pad[79:76]
	output logic [1:0]  m_tuser,   // status[1:0]
	// register writes, always taken
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	tfst_pkg::dp_cmd_t                     cmd;
	tfst_pkg::dp_stat_t                    stat;
	tfst_pkg::kind_t                       in_kind;
	logic [tfst_pkg::TID_W-1:0]            in_tenant;
	logic [tfst_pkg::CNT_W-1:0]            in_count;
	logic [1:0]                            out_status;
	logic signed [tfst_pkg::SFALL_W-1:0]   out_shortfall;
	logic                                  out_found;
	logic [tfst_pkg::TID_W-1:0]            out_best_tenant;
	logic [tfst_pkg::CNT_W-1:0]            out_best_held;
	logic [tfst_pkg::CNT_W-1:0]            out_best_excess;

	// unpack the input beat
	assign in_kind   = tfst_pkg::kind_t'(s_tuser);
	assign in_tenant = s_tdata[1:0];
	assign in_count  = s_tdata[25:2];

	// config registers are plain flops, a write lands in the cycle after it is presented
	assign cfg_ready = 1'b1;

	// sequencer: idle, update, or multiply/compare rounds, then result hand-off
	tfst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (in_kind),
		.in_tenant (in_tenant),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// counters, config, multiplier, working result and output register
	tfst_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_kind         (in_kind),
		.in_tenant       (in_tenant),
		.in_count        (in_count),
		.cmd             (cmd),
		.stat            (stat),
		.out_status      (out_status),
		.out_shortfall   (out_shortfall),
		.out_found       (out_found),
		.out_best_tenant (out_best_tenant),
		.out_best_held   (out_best_held),
		.out_best_excess (out_best_excess)
	);

	// pack the result beat, lowest field first
	assign m_tdata = {4'b0000, out_best_excess, out_best_held, out_best_tenant,
		out_found, out_shortfall};
	assign m_tuser = out_status;

endmodule

@@ src/tfst_checker.sv @@
`timescale 1ns / 1ps
`include "tenant_fair_share_tracker_macros.svh"
module tfst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [23:0] cfg_data
);

	// reset is sampled at a clock edge and the result valid is checked in the cycle after
	`TFST_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |=> !m_tvalid, "result beat during reset")

	`TFST_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

	`TFST_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")

	`TFST_ASSERT(a_unknown_clean, m_tvalid && m_tuser == tfst_pkg::STS_UNKNOWN |-> m_tdata[75:0] == '0, "unknown tenant with nonzero fields")

	`TFST_ASSERT(a_found_excess, m_tvalid && m_tdata[25] |-> m_tdata[75:52] != '0 && m_tuser == tfst_pkg::STS_OK, "borrower without excess")

endmodule

bind tenant_fair_share_tracker tfst_checker u_tfst_checker (.*);
